### rtl/tcsc_pkg.sv
package tcsc_pkg;

  localparam int unsigned TickW  = 21;
  localparam int unsigned SecW   = 17;
  localparam int unsigned HourW  = 5;
  localparam int unsigned RemW   = 12;
  localparam int unsigned WordW  = 30;

  localparam logic [TickW-1:0] OneDayTicks = 21'd1382400;
  localparam logic [11:0]      SecsPerHour = 12'd3600;
  localparam logic [5:0]       SecsPerMin  = 6'd60;

  // reciprocal multipliers, exact over the ranges they see
  localparam logic [15:0] HourRecip = 16'd37283;   // ceil(2^27 / 3600)
  localparam int unsigned HourShift = 27;
  localparam logic [12:0] MinRecip  = 13'd4370;    // ceil(2^18 / 60)
  localparam int unsigned MinShift  = 18;
  localparam logic [7:0]  TenRecip  = 8'd205;      // ceil(2^11 / 10)
  localparam int unsigned TenShift  = 11;

  localparam logic [1:0] AmMark = 2'b01;
  localparam logic [1:0] PmMark = 2'b10;

  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;
    logic       pm;
  } digits_t;

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'b1110111;
      4'd1:    s = 7'b0100100;
      4'd2:    s = 7'b1011101;
      4'd3:    s = 7'b1101101;
      4'd4:    s = 7'b0101110;
      4'd5:    s = 7'b1101011;
      4'd6:    s = 7'b1111011;
      4'd7:    s = 7'b0100101;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

### rtl/tcsc_seg_format.sv
module tcsc_seg_format import tcsc_pkg::*; (
  input  digits_t           digits,
  output logic [WordW-1:0]  word
);

  logic [6:0] hour_tens_seg;

  // hour tens stays dark when zero
  assign hour_tens_seg = (digits.hour_tens != 4'd0) ? seg_of(digits.hour_tens) : 7'b0000000;

  assign word = {(digits.pm ? PmMark : AmMark),
                 hour_tens_seg,
                 seg_of(digits.hour_ones),
                 seg_of(digits.minute_tens),
                 seg_of(digits.minute_ones)};

endmodule

### rtl/tick_count_to_segment_clock.sv
// Twelve-hour seven-segment clock formatter. Each transfer on the in_ channel
// carries a time of day in sixteenths of a second; the count is rounded to the
// nearest second, split into hour, minute and second, mapped onto a 12-hour
// face (hour 0 shows as 12 AM, hour 24 as 12 PM) and packed into a 30-bit
// segment word for a four-digit display with AM/PM lamps in bits 28-29. A
// count above one day gives range_error with every other field zero. The
// datapath is a five-stage pipeline built from constant reciprocal multiplies,
// so one count is taken every cycle while out_ does not stall, and its result
// reaches out_ through stages 1 to 4 and the output register. A stall on out_
// freezes the whole pipeline and is passed straight back on in_stall.
module tick_count_to_segment_clock import tcsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TickW-1:0]  in_sixteenth_seconds,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_range_error,
  output logic [WordW-1:0]  out_display_bits,
  output logic [3:0]        out_hours_12,
  output logic [5:0]        out_minutes,
  output logic [5:0]        out_seconds,
  output logic              out_is_pm
);

  // pipeline advances whenever the output register is free or being drained
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: range check and rounding to whole seconds
  logic            v1_r, err1_r;
  logic [SecW-1:0] ds1_r;
  logic [SecW-1:0] ds1_nxt;

  assign ds1_nxt = in_sixteenth_seconds[TickW-1:4] + {{(SecW-1){1'b0}}, in_sixteenth_seconds[3]};

  // stage 2: hour of day by reciprocal multiply
  logic             v2_r, err2_r;
  logic [SecW-1:0]  ds2_r;
  logic [HourW-1:0] hour2_r;
  logic [32:0]      hour_prod;

  assign hour_prod = {16'd0, ds1_r} * {17'd0, HourRecip};

  // stage 3: seconds left in the hour, 12-hour face
  logic             v3_r, err3_r, pm3_r;
  logic [RemW-1:0]  rem3_r;
  logic [3:0]       h12_3_r;
  logic [SecW-1:0]  hour_secs;
  logic [SecW-1:0]  rem_full;
  logic [3:0]       h12_nxt;

  assign hour_secs = {{(SecW-HourW){1'b0}}, hour2_r} * {{(SecW-12){1'b0}}, SecsPerHour};
  assign rem_full  = ds2_r - hour_secs;

  always_comb begin
    if (hour2_r == 5'd0) begin
      h12_nxt = 4'd12;
    end else if (hour2_r > 5'd12) begin
      h12_nxt = 4'(hour2_r - 5'd12);
    end else begin
      h12_nxt = hour2_r[3:0];
    end
  end

  // stage 4: minutes by reciprocal multiply
  logic            v4_r, err4_r, pm4_r;
  logic [RemW-1:0] rem4_r;
  logic [3:0]      h12_4_r;
  logic [5:0]      min4_r;
  logic [24:0]     min_prod;

  assign min_prod = {13'd0, rem3_r} * {12'd0, MinRecip};

  // stage 5 inputs: seconds, digit split, segment word
  logic [RemW-1:0] min_secs;
  logic [RemW-1:0] sec_full;
  logic [13:0]     ten_prod;
  logic [3:0]      minute_tens;
  logic [5:0]      minute_tens_x10;
  logic [5:0]      minute_ones;
  logic            h12_big;
  digits_t         digits;
  logic [WordW-1:0] word;

  assign min_secs        = {6'd0, min4_r} * {6'd0, SecsPerMin};
  assign sec_full        = rem4_r - min_secs;
  assign ten_prod        = {8'd0, min4_r} * {6'd0, TenRecip};
  assign minute_tens     = {1'b0, ten_prod[TenShift+2:TenShift]};
  assign minute_tens_x10 = {2'd0, minute_tens} * 6'd10;
  assign minute_ones     = min4_r - minute_tens_x10;
  assign h12_big         = (h12_4_r >= 4'd10);

  assign digits.hour_tens   = h12_big ? 4'd1 : 4'd0;
  assign digits.hour_ones   = h12_big ? 4'(h12_4_r - 4'd10) : h12_4_r;
  assign digits.minute_tens = minute_tens;
  assign digits.minute_ones = minute_ones[3:0];
  assign digits.pm          = pm4_r;

  tcsc_seg_format u_seg (
    .digits (digits),
    .word   (word)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      out_valid <= v4_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      err1_r  <= (in_sixteenth_seconds > OneDayTicks);
      ds1_r   <= ds1_nxt;

      err2_r  <= err1_r;
      ds2_r   <= ds1_r;
      hour2_r <= hour_prod[HourShift+HourW-1:HourShift];

      err3_r  <= err2_r;
      pm3_r   <= (hour2_r >= 5'd12);
      rem3_r  <= rem_full[RemW-1:0];
      h12_3_r <= h12_nxt;

      err4_r  <= err3_r;
      pm4_r   <= pm3_r;
      rem4_r  <= rem3_r;
      h12_4_r <= h12_3_r;
      min4_r  <= min_prod[MinShift+5:MinShift];

      // an out-of-range count zeroes every field but the error flag
      out_range_error  <= err4_r;
      out_display_bits <= err4_r ? '0 : word;
      out_hours_12     <= err4_r ? 4'd0 : h12_4_r;
      out_minutes      <= err4_r ? 6'd0 : min4_r;
      out_seconds      <= err4_r ? 6'd0 : sec_full[5:0];
      out_is_pm        <= err4_r ? 1'b0 : pm4_r;
    end
  end

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (out_display_bits == '0 && out_hours_12 == 4'd0 && out_minutes == 6'd0 &&
       out_seconds == 6'd0 && !out_is_pm))
    else $error("range error result carries nonzero fields");

  a_ampm_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |->
      ($onehot(out_display_bits[29:28]) && (out_display_bits[29] == out_is_pm)))
    else $error("am/pm lamps disagree with is_pm");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |->
      (out_hours_12 >= 4'd1 && out_hours_12 <= 4'd12 &&
       out_minutes <= 6'd59 && out_seconds <= 6'd59))
    else $error("time fields out of range");

endmodule

### tb/tick_count_to_segment_clock_tb.sv
module tick_count_to_segment_clock_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcsc_pkg::*;

  // one result field set, laid out at the block's widths
  typedef struct packed {
    logic             range_error;
    logic [WordW-1:0] display_bits;
    logic [3:0]       hours_12;
    logic [5:0]       minutes;
    logic [5:0]       seconds;
    logic             is_pm;
  } face_t;

  // one pending input transfer and the idle cycles that follow it
  typedef struct {
    logic [TickW-1:0] ticks;
    int unsigned      gap;
  } tick_item_t;

  // segment patterns, digit 9 first so that DigitSeg[d] picks digit d
  localparam logic [9:0][6:0] DigitSeg = {
    7'b1101111, 7'b1111111, 7'b0100101, 7'b1111011, 7'b1101011,
    7'b0101110, 7'b1101101, 7'b1011101, 7'b0100100, 7'b1110111
  };
  localparam int TicksPerHour = 57600;
  localparam int LongHold     = 80;     // receiver hold-off, long enough to back up the pipe
  localparam int DrainCycles  = 20;     // idle wait for stray results to leave the five-stage pipe
  localparam int TimeoutNs    = 2000000;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [TickW-1:0] in_sixteenth_seconds = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_range_error;
  logic [WordW-1:0] out_display_bits;
  logic [3:0]       out_hours_12;
  logic [5:0]       out_minutes;
  logic [5:0]       out_seconds;
  logic             out_is_pm;

  tick_item_t  tick_items[$];      // counts waiting to be offered
  face_t       expected_faces[$];  // predictions for counts already transferred
  tick_item_t  offered;
  face_t       oldest_face;
  logic        in_took = 1'b0;     // input transfer at the last rising edge
  logic        out_took = 1'b0;    // result transfer at the last rising edge
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw;
  int          hold_left = 0;
  int          long_holds_asked = 0;
  int          long_holds_given = 0;
  bit          sink_eager = 1'b0;  // receiver draws no random stalls while set
  int          counts_queued = 0;
  int          results_seen = 0;
  int          mismatches = 0;

  tick_count_to_segment_clock DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sixteenth_seconds (in_sixteenth_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_range_error      (out_range_error),
    .out_display_bits     (out_display_bits),
    .out_hours_12         (out_hours_12),
    .out_minutes          (out_minutes),
    .out_seconds          (out_seconds),
    .out_is_pm            (out_is_pm)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clock face for one count: round to the nearest second, split, and build the
  // segment word
  function automatic face_t predict_face(input logic [TickW-1:0] ticks);
    face_t       f;
    int unsigned whole_secs;
    int unsigned hour_of_day;
    int unsigned hour12;
    int unsigned mins;
    f = '0;
    // anything past one day only raises the error flag
    if (ticks > OneDayTicks) begin
      f.range_error = 1'b1;
      return f;
    end
    // bit 3 is the half-second, so it rounds up
    whole_secs  = int'(ticks >> 4) + int'(ticks[3]);
    hour_of_day = whole_secs / 3600;
    f.is_pm     = (hour_of_day >= 12);
    // midnight shows as 12 AM; hour 24 (a full day) lands on 12 PM
    if (hour_of_day == 0) hour12 = 12;
    else if (hour_of_day > 12) hour12 = hour_of_day - 12;
    else hour12 = hour_of_day;
    mins = (whole_secs % 3600) / 60;
    f.display_bits[29:28] = f.is_pm ? PmMark : AmMark;
    // leading hour digit stays dark for 1..9
    if (hour12 >= 10) f.display_bits[27:21] = DigitSeg[hour12 / 10];
    f.display_bits[20:14] = DigitSeg[hour12 % 10];
    f.display_bits[13:7]  = DigitSeg[mins / 10];
    f.display_bits[6:0]   = DigitSeg[mins % 10];
    f.hours_12 = 4'(hour12);
    f.minutes  = 6'(mins);
    f.seconds  = 6'(whole_secs % 60);
    return f;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // monitor: predict on every input transfer, compare on every result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      // push first so a result transferred with its own count would still find its prediction
      if (in_valid && !in_stall) expected_faces.push_back(predict_face(in_sixteenth_seconds));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_faces.size() == 0) begin
          $error("result transfer with no count outstanding");
          mismatches++;
        end else begin
          oldest_face = expected_faces.pop_front();
          check_field("range_error", 32'(oldest_face.range_error), 32'(out_range_error));
          check_field("display_bits", 32'(oldest_face.display_bits), 32'(out_display_bits));
          check_field("hours_12", 32'(oldest_face.hours_12), 32'(out_hours_12));
          check_field("minutes", 32'(oldest_face.minutes), 32'(out_minutes));
          check_field("seconds", 32'(oldest_face.seconds), 32'(out_seconds));
          check_field("is_pm", 32'(oldest_face.is_pm), 32'(out_is_pm));
        end
      end
    end
  end

  // driver: a new count goes out only once the held one has transferred, so the
  // payload never moves under a stall and valid stays high across back-to-back items
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_took) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (tick_items.size() != 0) begin
        offered = tick_items.pop_front();
        in_sixteenth_seconds <= offered.ticks;
        gap_left <= offered.gap;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: a random stall after each result, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (long_holds_given != long_holds_asked) begin
      long_holds_given <= long_holds_given + 1;
      hold_left <= LongHold - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (out_took && !sink_eager) begin
      stall_draw = $urandom_range(0, 4);
      stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left != 0 && !sink_eager) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_count(input logic [TickW-1:0] ticks, input int unsigned gap);
    tick_item_t item;
    item.ticks = ticks;
    item.gap   = gap;
    tick_items.push_back(item);
    counts_queued++;
  endtask

  // mostly legal times, some near the day and hour edges, some anywhere in 21 bits
  task automatic queue_random(input int n, input bit busy);
    int          v;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        v = int'($urandom_range(0, OneDayTicks));
      end else if (pick < 8) begin
        v = int'(OneDayTicks) - 24 + int'($urandom_range(0, 48));
      end else if (pick < 9) begin
        v = int'($urandom_range(0, 24)) * TicksPerHour + int'($urandom_range(0, 47)) - 24;
        if (v < 0) v = 0;
      end else begin
        v = int'($urandom & 32'h001F_FFFF);
      end
      queue_count(v[TickW-1:0], busy ? 0 : $urandom_range(0, 4));
    end
  endtask

  // sender pause: every queued count has come back as a result
  task automatic wait_drained();
    while (results_seen != counts_queued) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed corners: rounding, hour and day edges, error range
    @(posedge clk);
    queue_count(21'd0, $urandom_range(0, 4));        // midnight, 12 AM
    queue_count(21'd7, $urandom_range(0, 4));        // just under a half second
    queue_count(21'd8, $urandom_range(0, 4));        // half second rounds up
    queue_count(21'd24, $urandom_range(0, 4));
    queue_count(21'd951, $urandom_range(0, 4));      // 0:00:59
    queue_count(21'd952, $urandom_range(0, 4));      // rounds over to 0:01:00
    queue_count(21'd57592, $urandom_range(0, 4));    // rounds up to 1 AM
    queue_count(21'd57600, $urandom_range(0, 4));    // 1 AM
    queue_count(21'd576000, $urandom_range(0, 4));   // 10 AM, tens digit lit
    queue_count(21'd691183, $urandom_range(0, 4));   // 11:59:59 AM
    queue_count(21'd691192, $urandom_range(0, 4));   // rounds up to noon
    queue_count(21'd691200, $urandom_range(0, 4));   // noon, PM
    queue_count(21'd748800, $urandom_range(0, 4));   // 1 PM, hour drops by 12
    queue_count(21'd1267200, $urandom_range(0, 4));  // 10 PM
    queue_count(21'd1382384, $urandom_range(0, 4));  // 11:59:59 PM
    queue_count(21'd1382392, $urandom_range(0, 4));  // rounds up to a full day
    queue_count(21'd1382399, $urandom_range(0, 4));
    queue_count(21'd1382400, $urandom_range(0, 4));  // exactly one day, 12 PM
    queue_count(21'd1382401, $urandom_range(0, 4));  // first out-of-range count
    queue_count(21'h155555, $urandom_range(0, 4));   // out of range, alternating bits
    queue_count(21'h0AAAAA, $urandom_range(0, 4));   // legal, alternating bits
    queue_count(21'h100000, $urandom_range(0, 4));
    queue_count(21'h1FFFFF, $urandom_range(0, 4));   // largest count, error
    wait_drained();

    // random counts with idling on both sides
    @(posedge clk);
    queue_random(300, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps offering, so in_stall backs up
    @(posedge clk);
    long_holds_asked++;
    queue_random(60, 1'b1);
    wait_drained();

    // full rate, no idling anywhere
    @(posedge clk);
    sink_eager = 1'b1;
    queue_random(200, 1'b1);
    wait_drained();

    @(posedge clk);
    sink_eager = 1'b0;
    queue_random(520, 1'b0);
    wait_drained();

    // let anything stray fall out of the pipe
    repeat (DrainCycles) @(negedge clk);
    if (expected_faces.size() != 0) begin
      $error("%0d predicted results never arrived", expected_faces.size());
    end
    if (mismatches == 0 && expected_faces.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
rtl/tcsc_pkg.sv
rtl/tcsc_seg_format.sv
rtl/tick_count_to_segment_clock.sv
tb/tick_count_to_segment_clock_tb.sv
